[rtl/gsa_pkg.sv]
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the gated sweep averager
// Request structs, op codes, field widths and the shared adder interface.
// ----------------------------------------------------------------------------
package gsa_pkg;

	// default store depth and fixed field widths
	localparam int DEPTH_DEF   = 1024;
	localparam int SAMPLE_BITS = 12;
	localparam int OP_W        = 2;
	localparam int POS_W       = 10;
	localparam int VLEN_W      = 11;
	localparam int AVG_W       = 12;
	localparam int CFG_W       = 8;
	localparam int ACC_W       = 20;
	localparam int ALU_W       = ACC_W + 1;

	// request op codes
	localparam logic [OP_W-1:0] OP_START  = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	// reset value of the sweep count register
	localparam logic [CFG_W-1:0] CFG_RESET = 8'd1;

	// saturation limits
	localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
	localparam logic [AVG_W-1:0]  AVG_MAX  = '1;
	localparam logic [VLEN_W-1:0] VLEN_MAX = '1;

	// input request
	typedef struct packed {
		logic [OP_W-1:0]        op;
		logic                   gate;
		logic [SAMPLE_BITS-1:0] sample;
		logic [POS_W-1:0]       read_position;
	} in_t;

	// result
	typedef struct packed {
		logic [AVG_W-1:0]  average;
		logic [POS_W-1:0]  point_index;
		logic [VLEN_W-1:0] valid_length;
		logic              run_done;
		logic              in_range;
	} out_t;

	// shared adder operation
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             carry;
	} alu_rsp_t;

endpackage

[rtl/gsa_alu.sv]
// ----------------------------------------------------------------------------
// gsa_alu: shared add / subtract unit
// Serves the accumulate step and every step of the restoring divider.
// On a subtract, carry high means a >= b.
// ----------------------------------------------------------------------------
module gsa_alu (
	input  gsa_pkg::alu_req_t req,
	output gsa_pkg::alu_rsp_t rsp
);
	import gsa_pkg::*;

	logic [ALU_W-1:0] b_eff;
	logic [ALU_W:0]   total;

	// two's complement subtract through the same adder
	always_comb begin
		b_eff     = (req.op == ALU_SUB) ? ~req.b : req.b;
		total     = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, (req.op == ALU_SUB)};
		rsp.res   = total[ALU_W-1:0];
		rsp.carry = total[ALU_W];
	end

endmodule

[rtl/gsa_mem.sv]
// ----------------------------------------------------------------------------
// gsa_mem: accumulator store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gsa_mem #(
	parameter int DEPTH  = gsa_pkg::DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = gsa_pkg::ACC_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/gated_sweep_averager.sv]
// ----------------------------------------------------------------------------
// gated_sweep_averager: coherent averaging over gated sweeps
// Accumulates samples per sweep position while the gate is high and returns
// the per-position sum divided by the sweep count on read requests.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready  gsa_pkg::in_t  (op, gate, sample, position)
//  out       output     out_valid/out_ready  gsa_pkg::out_t (average, index, length, flags)
//  cfg       input      cfg_we               cfg_wdata (sweeps to average)
//
// A sample request that updates no accumulator ends in the idle state;
// otherwise a store read follows, then an add and write back on the shared adder.
// A read request runs a store read, then 20 divider steps on the shared
// adder, one bit of quotient per step, then the output load; a read at or
// beyond the valid length skips store and divider.
// A start request and reset both run a clearing pass over every store entry,
// during which no request is taken; configuration writes still land.
// A result waiting in the output register stalls only the next read request.
// ----------------------------------------------------------------------------
module gated_sweep_averager #(
	parameter int DEPTH = gsa_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  gsa_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output gsa_pkg::out_t             out_data,
	input  logic                      cfg_we,
	input  logic [gsa_pkg::CFG_W-1:0] cfg_wdata
);
	import gsa_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = (LEN_W > VLEN_W) ? LEN_W : VLEN_W;
	localparam int CNT_W  = $clog2(ACC_W);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SRD,
		ST_SADD,
		ST_RRD,
		ST_RLD,
		ST_DIV,
		ST_PUT
	} state_t;

	typedef enum logic [1:0] {
		PH_WAIT_LOW,
		PH_WAIT_HIGH,
		PH_CAPTURE,
		PH_DONE
	} phase_t;

	state_t                 state_q;
	phase_t                 phase_q;
	logic [CFG_W-1:0]       cfg_q;
	logic [LEN_W-1:0]       pos_q;
	logic [LEN_W-1:0]       short_q;
	logic [CFG_W-1:0]       sweeps_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [SAMPLE_BITS-1:0] samp_q;
	logic [CFG_W-1:0]       div_q;
	logic [CFG_W-1:0]       rem_q;
	logic [ACC_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [POS_W-1:0]       rp_q;
	logic                   inr_q;
	logic                   out_valid_q;
	out_t                   out_q;

	logic [LEN_W-1:0]  pos_eff;
	logic              pos_room;
	logic              pos_keep;
	logic [CMP_W-1:0]  rp_cmp;
	logic              rd_inr;
	logic [CFG_W-1:0]  sweeps_inc;
	logic [LEN_W-1:0]  end_short;
	logic              take;
	logic [CFG_W-1:0]  rem_next;
	logic [ACC_W-1:0]  sum_sat;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ACC_W-1:0]  mem_wdata;
	logic              mem_re;
	logic [ACC_W-1:0]  mem_rdata;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	// accumulator store
	gsa_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (ACC_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	// shared adder
	gsa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// request decode helpers
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		pos_eff    = (phase_q == PH_WAIT_HIGH) ? '0 : pos_q;
		pos_room   = pos_eff < LEN_W'(DEPTH);
		pos_keep   = pos_room && (pos_eff < short_q);
		rp_cmp     = CMP_W'(in_data.read_position);
		rd_inr     = (rp_cmp < CMP_W'(short_q)) && (rp_cmp < CMP_W'(DEPTH));
		sweeps_inc = (sweeps_q == '1) ? sweeps_q : sweeps_q + 1'b1;
		end_short  = (pos_q < short_q) ? pos_q : short_q;
	end

	// shared adder operand selection
	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			ST_SADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = ALU_W'(mem_rdata);
				alu_req.b  = ALU_W'(samp_q);
			end
			ST_DIV: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = ALU_W'({rem_q, quo_q[ACC_W-1]});
				alu_req.b  = ALU_W'(div_q);
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
		sum_sat  = alu_rsp.res[ACC_W] ? ACC_MAX : alu_rsp.res[ACC_W-1:0];
		take     = alu_rsp.carry;
		rem_next = take ? alu_rsp.res[CFG_W-1:0] : {rem_q[CFG_W-2:0], quo_q[ACC_W-1]};
	end

	// store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = sum_sat;
		mem_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_SADD: begin
				mem_we = 1'b1;
			end
			ST_SRD, ST_RRD: begin
				mem_re = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// sequencer, sweep tracking and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			phase_q     <= PH_WAIT_LOW;
			cfg_q       <= CFG_RESET;
			pos_q       <= '0;
			short_q     <= LEN_W'(DEPTH);
			sweeps_q    <= '0;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			// a result leaving while the next one is loaded is handled in ST_PUT
			if (out_valid_q && out_ready && state_q != ST_PUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				// clearing pass over the store
				ST_CLEAR: begin
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				// take a request
				ST_IDLE: begin
					if (in_valid) begin
						unique case (in_data.op)
							OP_START: begin
								phase_q  <= PH_WAIT_LOW;
								pos_q    <= '0;
								short_q  <= LEN_W'(DEPTH);
								sweeps_q <= '0;
								clr_q    <= '0;
								state_q  <= ST_CLEAR;
							end
							OP_SAMPLE: begin
								unique case (phase_q)
									PH_WAIT_LOW: begin
										if (!in_data.gate) begin
											phase_q <= PH_WAIT_HIGH;
										end
									end
									PH_WAIT_HIGH, PH_CAPTURE: begin
										if (in_data.gate) begin
											phase_q <= PH_CAPTURE;
											pos_q   <= pos_room ? pos_eff + 1'b1 : pos_eff;
											addr_q  <= ADDR_W'(pos_eff);
											samp_q  <= in_data.sample;
											if (pos_keep) begin
												state_q <= ST_SRD;
											end
										end else if (phase_q == PH_CAPTURE) begin
											// gate fell: sweep ends
											short_q  <= end_short;
											pos_q    <= '0;
											sweeps_q <= sweeps_inc;
											phase_q  <= (sweeps_inc >= cfg_q) ? PH_DONE
											                                  : PH_WAIT_HIGH;
										end
									end
									PH_DONE: begin
										phase_q <= PH_DONE;
									end
								endcase
							end
							OP_READ: begin
								rp_q    <= in_data.read_position;
								inr_q   <= rd_inr;
								addr_q  <= ADDR_W'(in_data.read_position);
								div_q   <= (cfg_q == '0) ? CFG_W'(1) : cfg_q;
								quo_q   <= '0;
								state_q <= rd_inr ? ST_RRD : ST_PUT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				// sample accumulate
				ST_SRD: begin
					state_q <= ST_SADD;
				end
				ST_SADD: begin
					state_q <= ST_IDLE;
				end
				// read and divide
				ST_RRD: begin
					state_q <= ST_RLD;
				end
				ST_RLD: begin
					quo_q   <= mem_rdata;
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[ACC_W-2:0], take};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ACC_W - 1)) begin
						state_q <= ST_PUT;
					end
				end
				// load the result register once it is free
				ST_PUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_q.average     <= !inr_q ? '0 :
						                     (quo_q > ACC_W'(AVG_MAX)) ? AVG_MAX
						                                               : quo_q[AVG_W-1:0];
						out_q.point_index <= rp_q;
						out_q.valid_length <= (CMP_W'(short_q) > CMP_W'(VLEN_MAX)) ? VLEN_MAX
						                                                           : VLEN_W'(short_q);
						out_q.run_done    <= (phase_q == PH_DONE);
						out_q.in_range    <= inr_q;
						state_q           <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// the valid length only shrinks between start requests
	a_short_shrinks : assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready && in_data.op == OP_START) |=> short_q <= $past(short_q))
		else $error("valid length grew without a start request");

	// the sweep position never runs past the store
	a_pos_bound : assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LEN_W'(DEPTH))
		else $error("sweep position beyond store depth");

	// a finished run has at least one sweep behind it
	a_done_sweeps : assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> sweeps_q != '0)
		else $error("run marked done with no sweep counted");

	// an accumulate write always follows its store read
	a_add_after_read : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SADD |-> $past(state_q) == ST_SRD)
		else $error("accumulate without preceding store read");
`endif

endmodule

[test/tb_gated_sweep_averager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_sweep_averager: self-checking bench for the gated sweep averager
// Start, sample and read requests go in with random gaps on both channels.
// A behavioural copy of the per-position sums predicts each read result,
// which is compared field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb_gated_sweep_averager;
	import gsa_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = DEPTH_DEF + 64;
	localparam int RANDOM_ITEMS  = 480;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		SWEEP_WAIT_LOW,
		SWEEP_WAIT_HIGH,
		SWEEP_CAPTURE,
		SWEEP_DONE
	} sweep_phase_t;

	// request waiting to go out, optionally held until all reads are answered
	typedef struct {
		in_t req;
		bit  drain;
	} queued_req_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// behavioural copy of the averaging state
	logic [ACC_W-1:0]  sum_model [DEPTH_DEF];
	logic [VLEN_W-1:0] shortest_len;
	logic [VLEN_W-1:0] sweep_pos;
	logic [7:0]        sweeps_seen;
	sweep_phase_t      sweep_phase;
	logic [CFG_W-1:0]  sweeps_cfg;

	out_t        average_q[$];
	queued_req_t request_q[$];

	int   outstanding  = 0;
	int   items_queued = 0;
	int   fail_count   = 0;
	int   cycle_count  = 0;
	int   send_gap     = 0;
	int   ready_left   = 0;
	logic req_taken    = 1'b0;
	logic no_idle      = 1'b0;

	gated_sweep_averager i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// ---------------------------------------------------------------- model

	function automatic void clear_run();
		foreach (sum_model[i])
			sum_model[i] = '0;
		shortest_len = VLEN_W'(DEPTH_DEF);
		sweep_pos    = '0;
		sweeps_seen  = '0;
		sweep_phase  = SWEEP_WAIT_LOW;
	endfunction

	// add one sample at the current position, dropping anything past the store or the valid length
	function automatic void accumulate(logic [SAMPLE_BITS-1:0] adc);
		logic [ACC_W:0] total;
		if (sweep_pos < VLEN_W'(DEPTH_DEF)) begin
			if (sweep_pos < shortest_len) begin
				total = (ACC_W+1)'(sum_model[sweep_pos[POS_W-1:0]]) + (ACC_W+1)'(adc);
				sum_model[sweep_pos[POS_W-1:0]] = (total > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX
					: total[ACC_W-1:0];
			end
			sweep_pos++;
		end
	endfunction

	// gate fell: shrink the valid length and count the sweep
	function automatic void close_sweep();
		if (sweep_pos < shortest_len)
			shortest_len = sweep_pos;
		sweep_pos = '0;
		if (sweeps_seen != 8'hFF)
			sweeps_seen++;
		sweep_phase = (sweeps_seen >= sweeps_cfg) ? SWEEP_DONE : SWEEP_WAIT_HIGH;
	endfunction

	function automatic void apply_request(in_t r);
		out_t             res;
		logic [CFG_W-1:0] divisor;
		logic [ACC_W-1:0] quotient;
		case (r.op)
			OP_START: clear_run();
			OP_SAMPLE: begin
				case (sweep_phase)
					SWEEP_WAIT_LOW: begin
						if (!r.gate)
							sweep_phase = SWEEP_WAIT_HIGH;
					end
					SWEEP_WAIT_HIGH: begin
						if (r.gate) begin
							sweep_phase = SWEEP_CAPTURE;
							sweep_pos   = '0;
							accumulate(r.sample);
						end
					end
					SWEEP_CAPTURE: begin
						if (r.gate)
							accumulate(r.sample);
						else
							close_sweep();
					end
					default: ;
				endcase
			end
			OP_READ: begin
				// a zero sweep count divides by one
				divisor          = (sweeps_cfg == '0) ? CFG_W'(1) : sweeps_cfg;
				res.point_index  = r.read_position;
				res.in_range     = (VLEN_W'(r.read_position) < shortest_len);
				res.average      = '0;
				if (res.in_range) begin
					quotient    = sum_model[r.read_position] / ACC_W'(divisor);
					res.average = (quotient > ACC_W'(AVG_MAX)) ? AVG_MAX
						: quotient[AVG_W-1:0];
				end
				res.valid_length = shortest_len;
				res.run_done     = (sweep_phase == SWEEP_DONE);
				average_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	function automatic void push_req(logic [OP_W-1:0] op, logic gate,
			logic [SAMPLE_BITS-1:0] adc, logic [POS_W-1:0] pos, bit drain = 1'b0);
		queued_req_t q;
		q.req.op            = op;
		q.req.gate          = gate;
		q.req.sample        = adc;
		q.req.read_position = pos;
		q.drain             = drain;
		request_q.push_back(q);
		outstanding++;
		items_queued++;
	endfunction

	function automatic void push_start();
		push_req(OP_START, 1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom),
			POS_W'($urandom));
	endfunction

	function automatic void push_tick(logic gate, logic [SAMPLE_BITS-1:0] adc);
		push_req(OP_SAMPLE, gate, adc, POS_W'($urandom));
	endfunction

	function automatic void push_read(logic [POS_W-1:0] pos, bit drain = 1'b0);
		push_req(OP_READ, 1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom), pos, drain);
	endfunction

	// positions near typical sweep lengths, sometimes anywhere
	function automatic logic [POS_W-1:0] rand_pos();
		if ($urandom_range(0, 9) < 7)
			return POS_W'($urandom_range(0, 40));
		return POS_W'($urandom_range(0, 1023));
	endfunction

	// gate low for a few ticks, then high for len ticks, with stray reads
	function automatic void push_sweep(int len, int lo, int hi);
		repeat ($urandom_range(1, 3))
			push_tick(1'b0, SAMPLE_BITS'($urandom));
		for (int i = 0; i < len; i++) begin
			push_tick(1'b1, SAMPLE_BITS'($urandom_range(lo, hi)));
			if ($urandom_range(0, 9) == 0)
				push_read(rand_pos());
		end
	endfunction

	// mostly well-formed runs, with missing starts, flickering gates and junk ops
	function automatic void push_random_run(int sweeps);
		int len;
		if ($urandom_range(0, 9) != 0)
			push_start();
		for (int s = 0; s < sweeps; s++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 9) == 0) begin
				repeat (len)
					push_tick(1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom));
			end else begin
				push_sweep(len, 0, 4095);
			end
			if ($urandom_range(0, 19) == 0)
				push_req(OP_UNUSED, 1'($urandom_range(0, 1)), SAMPLE_BITS'($urandom),
					POS_W'($urandom));
		end
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		repeat ($urandom_range(2, 6))
			push_read(rand_pos(), $urandom_range(0, 15) == 0);
	endfunction

	// wait until the block is idle, then write the sweep count
	task automatic set_sweeps(logic [CFG_W-1:0] value);
		do @(negedge clk); while (outstanding != 0 || average_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata  <= value;
		cfg_we     <= 1'b1;
		sweeps_cfg  = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endfunction

	// ---------------------------------------------------------------- driver

	// request side: hold until taken, then gap, then the next queued request
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (request_q.size() != 0
					&& !(request_q[0].drain && average_q.size() != 0)) begin
				in_data  <= request_q[0].req;
				in_valid <= 1'b1;
				void'(request_q.pop_front());
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side: random stalls of mixed length
	always @(negedge clk) begin
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else if (!no_idle && $urandom_range(0, 2) == 0) begin
			out_ready  <= 1'b0;
			ready_left <= pick_gap();
		end else begin
			out_ready  <= 1'b1;
			ready_left <= $urandom_range(0, 6);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : monitor
		out_t want;
		req_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			outstanding--;
			apply_request(in_data);
		end
		if (arst_n && out_valid && out_ready) begin
			if (average_q.size() == 0) begin
				$error("unexpected result for position %0d", out_data.point_index);
				fail_count++;
			end else begin
				want = average_q.pop_front();
				check_field("average", 32'(want.average), 32'(out_data.average));
				check_field("point_index", 32'(want.point_index),
					32'(out_data.point_index));
				check_field("valid_length", 32'(want.valid_length),
					32'(out_data.valid_length));
				check_field("run_done", 32'(want.run_done), 32'(out_data.run_done));
				check_field("in_range", 32'(want.in_range), 32'(out_data.in_range));
			end
		end
	end

	// cycle limit and stretches without idling
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 256 == 0)
			no_idle <= ($urandom_range(0, 3) == 0);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		int base;
		clear_run();
		sweeps_cfg = CFG_RESET;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: two sweeps of different length at a count of two
		set_sweeps(8'd2);
		push_read(10'd0);
		push_read(10'h3FF);
		push_req(OP_UNUSED, 1'b1, 12'hFFF, 10'h3FF);
		push_tick(1'b1, 12'hFFF);
		push_tick(1'b0, 12'h000);
		push_tick(1'b1, 12'hFFF);
		push_tick(1'b1, 12'h000);
		push_tick(1'b1, 12'hAAA);
		push_tick(1'b1, 12'h555);
		push_tick(1'b0, 12'hFFF);
		push_tick(1'b1, 12'hFFF);
		push_tick(1'b1, 12'hFFF);
		push_tick(1'b0, 12'h000);
		push_read(10'd0);
		push_read(10'd1);
		push_read(10'd2);
		// samples after the run is done are ignored
		push_tick(1'b1, 12'hFFF);
		push_read(10'h2AA, 1'b1);
		push_read(10'h155);
		push_start();
		push_read(10'd0);

		// zero sweep count: divide by one, done after the first sweep
		set_sweeps(8'd0);
		push_start();
		push_sweep(5, 0, 4095);
		push_sweep(3, 0, 4095);
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		for (int i = 0; i < 7; i++)
			push_read(POS_W'(i));

		// full count, then lowered mid run so the sums overflow the average
		set_sweeps(8'd255);
		push_start();
		repeat (3)
			push_sweep(6, 3500, 4095);
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		for (int i = 0; i < 7; i++)
			push_read(POS_W'(i));
		set_sweeps(8'd1);
		push_read(10'd0, 1'b1);
		for (int i = 1; i < 6; i++)
			push_read(POS_W'(i));
		push_sweep(6, 0, 4095);
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		for (int i = 0; i < 7; i++)
			push_read(POS_W'(i));

		// long sweep, then a short one that cuts the valid length
		set_sweeps(8'd3);
		push_start();
		push_sweep(40, 0, 4095);
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		push_read(10'h3FF);
		push_read(10'd39);
		push_sweep(10, 0, 4095);
		push_tick(1'b0, SAMPLE_BITS'($urandom));
		push_read(10'd9);
		push_read(10'd10);
		push_read(10'h3FF);

		// random runs under assorted sweep counts
		base = items_queued;
		while (items_queued < base + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: set_sweeps(8'd0);
				1: set_sweeps(8'd255);
				default: set_sweeps(CFG_W'($urandom_range(1, 6)));
			endcase
			push_random_run($urandom_range(1, (sweeps_cfg > 6) ? 4 : sweeps_cfg + 2));
		end

		// drain, then give a late result time to show up
		do @(negedge clk); while (outstanding != 0 || average_q.size() != 0);
		repeat (64) @(negedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
